>>> rtl/mklf_pkg.sv
// shared types, constants and register indexes for the multi keyword line filter
package mklf_pkg;

  localparam int MAX_KEYWORDS_DEF       = 8;
  localparam int MAX_KEYWORD_LENGTH_DEF = 16;

  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 8;
  localparam int ADDR_W    = 7;
  localparam int ADDR_SPAN = 128;

  localparam logic [CFG_IDX_W-1:0] REG_USED_KEYWORDS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ANY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE_FILE_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LINES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ADDRESS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_DATA    = 3'd7;

  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [COUNT_W-1:0] used_keywords;
    logic               match_any;
    logic               whole_file_mode;
    logic               list_lines;
    logic               negate;
    logic               fold_case;
  } cfg_t;

  typedef struct packed {
    logic report_kind;
    logic file_matched;
    logic print_path;
    logic last_of_run;
  } result_t;

endpackage

>>> rtl/mklf_keyword_store.sv
// keyword byte store with per keyword length and reversed alignment
module mklf_keyword_store import mklf_pkg::*; #(
  parameter int MAX_KEYWORDS       = MAX_KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF,
  localparam int LW = $clog2(MAX_KEYWORD_LENGTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  output logic [LW-1:0]     kw_len [MAX_KEYWORDS],
  output logic [7:0]        kw_pat [MAX_KEYWORDS][MAX_KEYWORD_LENGTH]
);

  localparam int DEPTH = MAX_KEYWORDS * MAX_KEYWORD_LENGTH;

  logic [7:0]       store [DEPTH];
  logic [DEPTH-1:0] sel;

  for (genvar e = 0; e < DEPTH; e++) begin : g_entry
    localparam logic [31:0] E = e;
    if (E < ADDR_SPAN) begin : g_reach
      assign sel[e] = wr_en && (wr_addr == E[ADDR_W-1:0]);
    end else begin : g_beyond
      assign sel[e] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < DEPTH; n++) begin
      if (rst) begin
        store[n] <= '0;
      end else if (sel[n]) begin
        store[n] <= wr_data;
      end
    end
  end

  // length up to the first zero byte
  always_comb begin
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      kw_len[k] = LW'(MAX_KEYWORD_LENGTH);
      for (int j = MAX_KEYWORD_LENGTH - 1; j >= 0; j--) begin
        if (store[k*MAX_KEYWORD_LENGTH + j] == 8'h00) begin
          kw_len[k] = LW'(j);
        end
      end
    end
  end

  // position i holds the byte expected i places back from the newest byte
  always_comb begin
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      for (int i = 0; i < MAX_KEYWORD_LENGTH; i++) begin
        kw_pat[k][i] = '0;
        for (int l = 1; l <= MAX_KEYWORD_LENGTH; l++) begin
          if (i < l && kw_len[k] == LW'(l)) begin
            kw_pat[k][i] = kw_pat[k][i] | store[k*MAX_KEYWORD_LENGTH + l - 1 - i];
          end
        end
      end
    end
  end

endmodule

>>> rtl/mklf_scan.sv
// line history, keyword compare and line and file verdict logic
module mklf_scan import mklf_pkg::*; #(
  parameter int MAX_KEYWORDS       = MAX_KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF,
  localparam int LW = $clog2(MAX_KEYWORD_LENGTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [7:0]    data_in,
  input  logic          has_in,
  input  logic          eof_in,
  input  cfg_t          cfg,
  input  logic [LW-1:0] kw_len [MAX_KEYWORDS],
  input  logic [7:0]    kw_pat [MAX_KEYWORDS][MAX_KEYWORD_LENGTH],
  output logic [1:0]    res_count,
  output result_t       res0,
  output result_t       res1
);

  logic [7:0]              hist [MAX_KEYWORD_LENGTH];
  logic [LW-1:0]           fill;
  logic                    cut;
  logic [MAX_KEYWORDS-1:0] line_hit;
  logic [MAX_KEYWORDS-1:0] seen;
  logic                    file_hit;

  logic [7:0]              b_f;
  logic [7:0]              hist_next [MAX_KEYWORD_LENGTH];
  logic [LW-1:0]           fill_next;
  logic                    cut_next;
  logic [MAX_KEYWORDS-1:0] hits;
  logic [MAX_KEYWORDS-1:0] line_hit_next;
  logic [LW-1:0]           fill_after;
  logic [MAX_KEYWORDS-1:0] hit_after;
  logic [MAX_KEYWORDS-1:0] act;
  logic [MAX_KEYWORDS-1:0] empty;
  logic [MAX_KEYWORDS-1:0] m;
  logic [MAX_KEYWORDS-1:0] seen_next;
  logic                    close;
  logic                    line_ok;
  logic                    report;
  logic                    file_hit_next;
  logic                    line_rep;
  logic                    matched;
  logic                    vprint;
  result_t                 line_word;
  result_t                 verdict_word;

  always_comb begin
    b_f = data_in;
    if (cfg.fold_case && data_in >= CHAR_UC_A && data_in <= CHAR_UC_Z) begin
      b_f = data_in | CASE_BIT;
    end
  end

  always_comb begin
    hist_next[0] = b_f;
    for (int i = 1; i < MAX_KEYWORD_LENGTH; i++) begin
      hist_next[i] = hist[i-1];
    end
  end

  assign fill_next = (fill == LW'(MAX_KEYWORD_LENGTH)) ? fill : fill + LW'(1);
  assign cut_next  = cut || (b_f == 8'h00);

  always_comb begin
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      hits[k] = (kw_len[k] != '0) && (kw_len[k] <= fill_next);
      for (int i = 0; i < MAX_KEYWORD_LENGTH; i++) begin
        if (LW'(i) < kw_len[k] && hist_next[i] != kw_pat[k][i]) begin
          hits[k] = 1'b0;
        end
      end
      act[k]   = {{(32-COUNT_W){1'b0}}, cfg.used_keywords} > 32'(k);
      empty[k] = (kw_len[k] == '0);
    end
  end

  assign line_hit_next = line_hit | (cut_next ? '0 : hits);
  assign fill_after    = has_in ? fill_next : fill;
  assign hit_after     = has_in ? line_hit_next : line_hit;
  assign close         = (has_in && b_f == CHAR_LF) || (eof_in && fill_after != '0);
  assign m             = (hit_after | empty) & act;

  always_comb begin
    seen_next = seen;
    if (!cfg.whole_file_mode) begin
      line_ok = cfg.match_any ? (m != '0) : (m == act);
      report  = line_ok;
    end else begin
      report = (m != '0);
      if (cfg.match_any) begin
        line_ok = (m != '0);
      end else begin
        if (close) begin
          seen_next = seen | m;
        end
        line_ok = ((seen_next & act) == act);
      end
    end
  end

  assign file_hit_next = file_hit || (close && line_ok);
  assign line_rep      = close && report && cfg.list_lines && !cfg.negate;
  assign matched       = file_hit_next ^ cfg.negate;
  assign vprint        = matched && (!cfg.list_lines || cfg.negate);

  always_comb begin
    line_word.report_kind  = KIND_LINE;
    line_word.file_matched = 1'b0;
    line_word.print_path   = 1'b1;
    line_word.last_of_run  = !eof_in;
    verdict_word.report_kind  = KIND_VERDICT;
    verdict_word.file_matched = matched;
    verdict_word.print_path   = vprint;
    verdict_word.last_of_run  = 1'b1;
    res0 = line_rep ? line_word : verdict_word;
    res1 = verdict_word;
    res_count = {1'b0, line_rep} + {1'b0, eof_in};
  end

  always_ff @(posedge clk) begin
    if (go && has_in) begin
      for (int i = 0; i < MAX_KEYWORD_LENGTH; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      cut      <= 1'b0;
      line_hit <= '0;
      seen     <= '0;
      file_hit <= 1'b0;
    end else if (go) begin
      if (eof_in) begin
        fill     <= '0;
        cut      <= 1'b0;
        line_hit <= '0;
        seen     <= '0;
        file_hit <= 1'b0;
      end else if (close) begin
        fill     <= '0;
        cut      <= 1'b0;
        line_hit <= '0;
        seen     <= seen_next;
        file_hit <= file_hit_next;
      end else if (has_in) begin
        fill     <= fill_next;
        cut      <= cut_next;
        line_hit <= line_hit_next;
      end
    end
  end

endmodule

>>> rtl/mklf_out_fifo.sv
// result queue taking up to two words a cycle and giving one
module mklf_out_fifo import mklf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output logic       valid,
  output result_t    head,
  output logic       room
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  result_t        mem [OUT_DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;
  logic [PW-1:0]  wp_next;
  logic [CW-1:0]  count_next;

  assign valid      = (count != '0);
  assign head       = mem[rp];
  assign room       = (count <= CW'(OUT_DEPTH - 2));
  assign wp_next    = wp + PW'(push_count);
  assign count_next = count + CW'(push_count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wp] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wp + PW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

endmodule

>>> rtl/multi_keyword_line_filter_core.sv
// flow: an accepted word is held in the input register, scanned once the result queue has
// room, and its results are shown on the result port from that queue
// throughput: one word per cycle while the result queue has room; a word that closes a
// listed line at end of file gives two results, which leave the result queue one by one
// reset: synchronous, active high; empties all keywords, restores register defaults and
// clears line and file state
module multi_keyword_line_filter_core import mklf_pkg::*; #(
  parameter int MAX_KEYWORDS       = MAX_KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 has_byte,
  input  logic                 end_of_file,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 report_kind,
  output logic                 file_matched,
  output logic                 print_path,
  output logic                 last_of_run,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LW = $clog2(MAX_KEYWORD_LENGTH + 1);

  cfg_t              cfg;
  logic [ADDR_W-1:0] pattern_address;
  logic              q_valid;
  logic [7:0]        q_byte;
  logic              q_has;
  logic              q_eof;
  logic              advance;
  logic              accept;
  logic              room;
  logic [1:0]        res_count;
  result_t           res0;
  result_t           res1;
  result_t           head;
  logic [LW-1:0]     kw_len [MAX_KEYWORDS];
  logic [7:0]        kw_pat [MAX_KEYWORDS][MAX_KEYWORD_LENGTH];
  logic [COUNT_W-1:0] count_sat;

  assign advance  = q_valid && room;
  assign in_stall = q_valid && !room;
  assign accept   = in_valid && !in_stall;

  assign count_sat = ({{(32-COUNT_W){1'b0}}, cfg_data[COUNT_W-1:0]} > 32'(MAX_KEYWORDS))
                   ? COUNT_W'(MAX_KEYWORDS) : cfg_data[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.used_keywords   <= COUNT_W'(1);
      cfg.match_any       <= 1'b0;
      cfg.whole_file_mode <= 1'b0;
      cfg.list_lines      <= 1'b0;
      cfg.negate          <= 1'b0;
      cfg.fold_case       <= 1'b0;
      pattern_address     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_USED_KEYWORDS:   cfg.used_keywords   <= count_sat;
        REG_MATCH_ANY:       cfg.match_any       <= cfg_data[0];
        REG_WHOLE_FILE_MODE: cfg.whole_file_mode <= cfg_data[0];
        REG_LIST_LINES:      cfg.list_lines      <= cfg_data[0];
        REG_NEGATE:          cfg.negate          <= cfg_data[0];
        REG_FOLD_CASE:       cfg.fold_case       <= cfg_data[0];
        REG_PATTERN_ADDRESS: pattern_address     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= data_byte;
      q_has  <= has_byte;
      q_eof  <= end_of_file;
    end
  end

  mklf_keyword_store #(
    .MAX_KEYWORDS       (MAX_KEYWORDS),
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_write && cfg_index == REG_PATTERN_DATA),
    .wr_addr (pattern_address),
    .wr_data (cfg_data),
    .kw_len  (kw_len),
    .kw_pat  (kw_pat)
  );

  mklf_scan #(
    .MAX_KEYWORDS       (MAX_KEYWORDS),
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .data_in   (q_byte),
    .has_in    (q_has),
    .eof_in    (q_eof),
    .cfg       (cfg),
    .kw_len    (kw_len),
    .kw_pat    (kw_pat),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  mklf_out_fifo u_out (
    .clk        (clk),
    .rst        (rst),
    .push_count (advance ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_valid && !out_stall),
    .valid      (out_valid),
    .head       (head),
    .room       (room)
  );

  assign report_kind  = head.report_kind;
  assign file_matched = head.file_matched;
  assign print_path   = head.print_path;
  assign last_of_run  = head.last_of_run;

endmodule

>>> rtl/mklf_checker.sv
// port level checks for the multi keyword line filter and their binding
module mklf_checker import mklf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [7:0]           data_byte,
  input logic                 has_byte,
  input logic                 end_of_file,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 report_kind,
  input logic                 file_matched,
  input logic                 print_path,
  input logic                 last_of_run
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(has_byte)
      && $stable(end_of_file))
    else $error("input word changed while stalled");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_kind) && $stable(file_matched)
      && $stable(print_path) && $stable(last_of_run))
    else $error("result word changed while stalled");

  // line reports always print and never carry a verdict
  a_line_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_kind == KIND_LINE |-> print_path && !file_matched)
    else $error("malformed line report");

  // the verdict closes the run
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_kind == KIND_VERDICT |-> last_of_run)
    else $error("verdict not last of run");

  // the rest of a run is already queued behind a word that is not last
  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("run broken off");

endmodule

bind multi_keyword_line_filter_core mklf_checker u_mklf_checker (.*);
